// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file vpr_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define CHK_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("implication failed");
// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/vpr_pkg.sv -----
// package for the vertex projection pipeline: widths, register codes, helpers
// no dependencies
package vpr_pkg;
  localparam int CoordW = 32;
  localparam int NumRegs = 8;
  localparam int RegW = 64;
  localparam int RegIdxW = 3;
  localparam int PixW = 9;
  localparam int DefImageWidth = 512;
  localparam int DefImageHeight = 512;
  localparam int OneQ16 = 65536;

  typedef enum logic [RegIdxW-1:0] {
    REG_R0C01, REG_R0C23, REG_R1C01, REG_R1C23,
    REG_R2C01, REG_R2C23, REG_R3C01, REG_R3C23
  } reg_idx_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] w;
    logic last;
  } hvec_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic wz;
    logic last;
  } proj_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

// ----- rtl/vpr_transform.sv -----
// matrix multiply stages: products, then column sums
// depends on vpr_pkg
module vpr_transform import vpr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [CoordW-1:0] x,
  input  logic signed [CoordW-1:0] y,
  input  logic signed [CoordW-1:0] z,
  input  logic last,
  input  logic [RegW-1:0] regs [NumRegs],
  output logic out_valid,
  output hvec_t out
);
  logic signed [63:0] prod [3][4];
  logic signed [63:0] trans [4];
  logic last1, v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  // floor shift of each exact product
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          logic signed [31:0] m;
          logic signed [31:0] a;
          logic signed [63:0] p;
          m = regs[r*2 + c/2][(c%2)*32 +: 32];
          a = (r == 0) ? x : ((r == 1) ? y : z);
          p = a * m;
          prod[r][c] <= p >>> 16;
        end
      end
      for (int c = 0; c < 4; c++) begin
        trans[c] <= 64'(signed'(regs[6 + c/2][(c%2)*32 +: 32]));
      end
      last1 <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.x <= prod[0][0] + prod[1][0] + prod[2][0] + trans[0];
      out.y <= prod[0][1] + prod[1][1] + prod[2][1] + trans[1];
      out.z <= prod[0][2] + prod[1][2] + prod[2][2] + trans[2];
      out.w <= prod[0][3] + prod[1][3] + prod[2][3] + trans[3];
      out.last <= last1;
    end
  end
endmodule

// ----- rtl/vpr_divide.sv -----
// pipelined restoring divider: three quotients by w, one bit per stage
// depends on vpr_pkg
module vpr_divide import vpr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  hvec_t in,
  output logic out_valid,
  output proj_t out
);
  // numerators up to 2^63, scaled by 2^16: 80 quotient bits, pipeline of 80 steps
  localparam int NB = 80;
  localparam int St = NB;

  logic [St:0] v;
  logic [NB-1:0] num [St+1][3];
  logic [64:0] rem [St+1][3];
  logic [63:0] den [St+1];
  logic [2:0] neg [St+1];
  logic signed [63:0] raw [St+1][3];
  logic unity [St+1];
  logic wzero [St+1];
  logic lst [St+1];

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  always_comb begin
    v[0] = in_valid;
    den[0] = mag(in.w);
    raw[0][0] = in.x; raw[0][1] = in.y; raw[0][2] = in.z;
    for (int k = 0; k < 3; k++) begin
      num[0][k] = {mag(raw[0][k]), 16'd0};
      rem[0][k] = '0;
      neg[0][k] = raw[0][k][63] ^ in.w[63];
    end
    unity[0] = (in.w == 64'sd65536);
    wzero[0] = (in.w == 64'sd0);
    lst[0] = in.last;
  end

  for (genvar s = 0; s < St; s++) begin : g_st
    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else if (en) v[s+1] <= v[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          logic [64:0] t;
          t = {rem[s][k][63:0], num[s][k][NB-1]};
          if (t >= {1'b0, den[s]}) begin
            rem[s+1][k] <= t - {1'b0, den[s]};
            num[s+1][k] <= {num[s][k][NB-2:0], 1'b1};
          end else begin
            rem[s+1][k] <= t;
            num[s+1][k] <= {num[s][k][NB-2:0], 1'b0};
          end
          raw[s+1][k] <= raw[s][k];
        end
        den[s+1] <= den[s];
        neg[s+1] <= neg[s];
        unity[s+1] <= unity[s];
        wzero[s+1] <= wzero[s];
        lst[s+1] <= lst[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v[St];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [31:0] q;
        logic [NB-1:0] m;
        m = num[St][k];
        if (neg[St][k]) q = (m > NB'(64'h80000000)) ? 32'sh80000000 : 32'(-m);
        else q = (m > NB'(64'h7fffffff)) ? 32'sh7fffffff : 32'(m);
        if (wzero[St]) q = '0;
        else if (unity[St]) q = sat32(raw[St][k]);
        case (k)
          0: out.px <= q;
          1: out.py <= q;
          default: out.pz <= q;
        endcase
      end
      out.wz <= wzero[St];
      out.last <= lst[St];
    end
  end
endmodule

// ----- rtl/vpr_viewport.sv -----
// clip test and raster mapping, two stages
// depends on vpr_pkg
module vpr_viewport import vpr_pkg::*; #(
  parameter int IMAGE_WIDTH = DefImageWidth,
  parameter int IMAGE_HEIGHT = DefImageHeight
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  proj_t in,
  output logic out_valid,
  output proj_t out,
  output logic [PixW-1:0] pix_x,
  output logic [PixW-1:0] pix_y,
  output logic vis
);
  logic v1, vis1;
  proj_t p1;
  logic signed [63:0] t1, u1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [63:0] hx, lim;
      hx = 64'(in.px) * 64'(IMAGE_HEIGHT);
      lim = 64'(IMAGE_WIDTH) * 64'(OneQ16);
      vis1 <= !in.wz && hx <= lim && hx >= -lim &&
              in.py <= 32'sd65536 && in.py >= -32'sd65536;
      t1 <= (64'(in.px) + 64'sd65536) * 64'(IMAGE_WIDTH);
      u1 <= (64'sd65536 - 64'(in.py)) * 64'(IMAGE_HEIGHT);
      p1 <= in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [63:0] cx, cy;
      cx = (t1 <= 0) ? 64'sd0 : (t1 >>> 17);
      if (cx > 64'(IMAGE_WIDTH - 1)) cx = 64'(IMAGE_WIDTH - 1);
      cy = (u1 <= 0) ? 64'sd0 : (u1 >>> 17);
      if (cy > 64'(IMAGE_HEIGHT - 1)) cy = 64'(IMAGE_HEIGHT - 1);
      pix_x <= vis1 ? cx[PixW-1:0] : '0;
      pix_y <= vis1 ? cy[PixW-1:0] : '0;
      vis <= vis1;
      out <= p1;
    end
  end
endmodule

// ----- rtl/vertex_project_to_raster.sv -----
// top level of the vertex projection pipeline: registers, stages, output skid
// depends on vpr_pkg, vpr_transform, vpr_divide, vpr_viewport
// One vertex is accepted per cycle unless the two-entry output skid is full;
// results wait in the skid under output stalls. One result leaves per vertex,
// through 2 matrix stages, the divider stages of one quotient bit each and
// its output register, 2 viewport stages and the skid. The user must write
// matrix registers only while idle; the block does not enforce this.
module vertex_project_to_raster import vpr_pkg::*; #(
  parameter int IMAGE_WIDTH = DefImageWidth,
  parameter int IMAGE_HEIGHT = DefImageHeight
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [RegW-1:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // point_x, point_y, point_z
  input  logic s_axis_tlast,          // last_vertex
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [119:0] m_axis_tdata,  // proj_x, proj_y, proj_z, pixel_x, pixel_y, pad
  output logic [1:0] m_axis_tuser,    // visible, w_zero
  output logic m_axis_tlast           // last_out
);
  logic [RegW-1:0] regs [NumRegs];
  logic en, tv, dv, vv;
  hvec_t hv;
  proj_t dq, vq;
  logic [PixW-1:0] pxx, pxy;
  logic vis;
  logic [116:0] buf0, buf1, word;
  logic [1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_R0C01] <= 64'd65536;
      regs[REG_R0C23] <= '0;
      regs[REG_R1C01] <= 64'd65536 << 32;
      regs[REG_R1C23] <= '0;
      regs[REG_R2C01] <= '0;
      regs[REG_R2C23] <= 64'd65536;
      regs[REG_R3C01] <= '0;
      regs[REG_R3C23] <= 64'd65536 << 32;
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // pipeline advances unless the skid is full
  assign en = (cnt != 2'd2);
  assign s_axis_tready = en;

  vpr_transform u_xf (
    .clk, .rst, .en, .in_valid(s_axis_tvalid),
    .x(s_axis_tdata[31:0]), .y(s_axis_tdata[63:32]), .z(s_axis_tdata[95:64]),
    .last(s_axis_tlast), .regs, .out_valid(tv), .out(hv));
  vpr_divide u_div (.clk, .rst, .en, .in_valid(tv), .in(hv),
    .out_valid(dv), .out(dq));
  vpr_viewport #(.IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT)) u_vp (
    .clk, .rst, .en, .in_valid(dv), .in(dq), .out_valid(vv), .out(vq),
    .pix_x(pxx), .pix_y(pxy), .vis);

  assign word = {vq.last, vq.wz, vis, pxy, pxx, vq.pz, vq.py, vq.px};

  // skid: a result from the pipeline enters when en, leaves on output transfer
  always_ff @(posedge clk) begin
    logic pop, push;
    pop = m_axis_tvalid && m_axis_tready;
    push = en && vv;
    if (rst) cnt <= '0;
    else cnt <= cnt + 2'(push) - 2'(pop);
    if (pop) begin
      buf0 <= (push && cnt == 2'd1) ? word : buf1;
      if (push && cnt == 2'd2) buf1 <= word;
    end else if (push) begin
      if (cnt == 2'd0) buf0 <= word;
      else buf1 <= word;
    end
  end

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata = {6'd0, buf0[113:0]};
  assign m_axis_tuser = buf0[115:114];
  assign m_axis_tlast = buf0[116];
endmodule

// ----- rtl/vpr_checker.sv -----
// port-level checks for the vertex projection block, bound to the top level
// depends on vpr_pkg and assert_macros.svh
`include "assert_macros.svh"
module vpr_checker import vpr_pkg::*; (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [119:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser
);
  `CHK_IMPL(a_wz_hidden, clk, rst, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0])
  `CHK_IMPL(a_hidden_pix0, clk, rst, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[113:96] == 18'd0)
  `CHK_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `CHK_IMPL(a_ready_stall, clk, rst, !s_axis_tready, m_axis_tvalid)
endmodule

bind vertex_project_to_raster vpr_checker u_chk (.*);

// ----- sim/tb_vertex_project_to_raster.sv -----
// testbench for vertex_project_to_raster: random and directed vertices checked against a
// built-in fixed-point projection predictor, with bursty input and stalling output
// depends on vpr_pkg and the vertex_project_to_raster rtl
module tb_vertex_project_to_raster;
  import vpr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] x, y, z;
    logic last;
  } vertex_t;

  typedef struct {
    logic [31:0] px, py, pz;
    logic [8:0] cx, cy;
    logic vis, wz, last;
  } raster_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [RegIdxW-1:0] cfg_index = '0;
  logic [RegW-1:0] cfg_data = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [119:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  vertex_project_to_raster DUT (.*);

  always #5 clk = ~clk;

  logic [63:0] matrix_regs [NumRegs];
  vertex_t pending_vertices [$];
  raster_t expected_pixels [$];
  int mismatches = 0;
  int received = 0;
  int cycles = 0;
  int burst_left = 0, gap_left = 0;
  int stall_mode = 0;

  function automatic longint coef(int r, int c);
    logic [63:0] reg_v;
    reg_v = matrix_regs[r * 2 + c / 2];
    return (c % 2) ? longint'($signed(reg_v[63:32])) : longint'($signed(reg_v[31:0]));
  endfunction

  function automatic longint fshr16(longint p);
    return p >>> 16;  // arithmetic shift is floor
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint quot_q16(longint n, longint d);
    bit neg;
    logic [63:0] a, b, ip, rem, q;
    neg = (n < 0) != (d < 0);
    a = (n < 0) ? -n : n;
    b = (d < 0) ? -d : d;
    ip = a / b;
    rem = a % b;
    if (ip > 32768) return neg ? -64'sd2147483648 : 64'sd2147483647;
    q = ip;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= b) begin
        rem = rem - b;
        q[0] = 1'b1;
      end
    end
    return clamp32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic raster_t project_vertex(vertex_t v);
    raster_t r;
    longint x, y, z, h[4], px, py, pz, t, u, lim, cx, cy;
    bit vis, wz;
    x = $signed(v.x);
    y = $signed(v.y);
    z = $signed(v.z);
    for (int c = 0; c < 4; c++)
      h[c] = fshr16(x * coef(0, c)) + fshr16(y * coef(1, c)) + fshr16(z * coef(2, c))
             + coef(3, c);
    px = 0; py = 0; pz = 0; cx = 0; cy = 0; wz = 0; vis = 0;
    if (h[3] == 0) wz = 1;
    else if (h[3] == OneQ16) begin
      px = clamp32(h[0]); py = clamp32(h[1]); pz = clamp32(h[2]);
    end else begin
      px = quot_q16(h[0], h[3]); py = quot_q16(h[1], h[3]); pz = quot_q16(h[2], h[3]);
    end
    lim = longint'(DefImageWidth) * OneQ16;
    if (!wz)
      vis = px * DefImageHeight <= lim && px * DefImageHeight >= -lim &&
            py <= OneQ16 && py >= -OneQ16;
    if (vis) begin
      t = (px + OneQ16) * DefImageWidth;
      u = (OneQ16 - py) * DefImageHeight;
      cx = (t <= 0) ? 0 : (t >>> 17);
      if (cx > DefImageWidth - 1) cx = DefImageWidth - 1;
      cy = (u <= 0) ? 0 : (u >>> 17);
      if (cy > DefImageHeight - 1) cy = DefImageHeight - 1;
    end
    r.px = px[31:0]; r.py = py[31:0]; r.pz = pz[31:0];
    r.cx = cx[8:0]; r.cy = cy[8:0];
    r.vis = vis; r.wz = wz; r.last = v.last;
    return r;
  endfunction

  // driver: bursts and gaps; tvalid stays high across back-to-back transfers
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_pixels.push_back(project_vertex(pending_vertices.pop_front()));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 0;
        end else if (pending_vertices.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0) &&
                     pending_vertices.size() > 0) begin
          s_axis_tvalid <= 1;
          s_axis_tdata <= {pending_vertices[0].z, pending_vertices[0].y, pending_vertices[0].x};
          s_axis_tlast <= pending_vertices[0].last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else burst_left <= burst_left - 1;
        end else s_axis_tvalid <= 0;
      end
    end
  end

  // receiver stalls on its own changing pattern
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= (cycles % 7 < 3);
      default: m_axis_tready <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    raster_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      received <= received + 1;
      if (expected_pixels.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        e = expected_pixels.pop_front();
        if (m_axis_tdata[31:0] !== e.px || m_axis_tdata[63:32] !== e.py ||
            m_axis_tdata[95:64] !== e.pz || m_axis_tdata[104:96] !== e.cx ||
            m_axis_tdata[113:105] !== e.cy || m_axis_tdata[119:114] !== 6'd0 ||
            m_axis_tuser[0] !== e.vis || m_axis_tuser[1] !== e.wz ||
            m_axis_tlast !== e.last) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp px %h py %h pz %h cx %0d cy %0d vis %b wz %b last %b",
                     e.px, e.py, e.pz, e.cx, e.cy, e.vis, e.wz, e.last,
                     " / got px %h py %h pz %h cx %0d cy %0d vis %b wz %b last %b",
                     m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                     m_axis_tdata[104:96], m_axis_tdata[113:105], m_axis_tuser[0],
                     m_axis_tuser[1], m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("timeout with %0d results outstanding", expected_pixels.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_matrix(int idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx[RegIdxW-1:0];
    cfg_data <= val;
    matrix_regs[idx] = val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 131072) - 65536;
      2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
      default: return $urandom_range(0, 4096) - 2048;
    endcase
  endfunction

  function automatic logic [31:0] rand_entry(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 65536) - 32768;
      2: return $urandom_range(0, 1) ? 32'h00010000 : 32'h0;
      default: return $urandom_range(0, 262144) - 131072;
    endcase
  endfunction

  task automatic queue_vertex(logic [31:0] x, y, z, logic last);
    vertex_t v;
    v.x = x; v.y = y; v.z = z; v.last = last;
    pending_vertices.push_back(v);
  endtask

  task automatic drain;
    wait (pending_vertices.size() == 0 && !s_axis_tvalid);
    wait (expected_pixels.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_phase(int count, int cmode);
    for (int i = 0; i < count; i++)
      queue_vertex(rand_coord(cmode), rand_coord($urandom_range(0, 3)),
                   rand_coord(cmode), $urandom_range(0, 7) == 0);
  endtask

  logic [31:0] corner [6] = '{32'h0, 32'h00010000, 32'hffff0000, 32'h7fffffff,
                              32'h80000000, 32'h00008000};

  initial begin
    matrix_regs[0] = 64'h0000_0000_0001_0000;
    matrix_regs[1] = 64'h0;
    matrix_regs[2] = 64'h0001_0000_0000_0000;
    matrix_regs[3] = 64'h0;
    matrix_regs[4] = 64'h0;
    matrix_regs[5] = 64'h0000_0000_0001_0000;
    matrix_regs[6] = 64'h0;
    matrix_regs[7] = 64'h0001_0000_0000_0000;
    repeat (12) @(posedge clk);
    rst <= 0;
    // identity at reset: window edges, extremes, last flag
    for (int i = 0; i < 6; i++) queue_vertex(corner[i], corner[5 - i], corner[i], i[0]);
    queue_vertex(32'h00010001, 32'h0, 32'h0, 0);
    queue_vertex(32'h0, 32'hfffeffff, 32'h0, 1);
    drain();
    // w taken from z: zero w, w of -1, small w for saturation
    write_matrix(REG_R2C23, 64'h0001_0000_0001_0000);
    write_matrix(REG_R3C23, 64'h0);
    queue_vertex(32'h00008000, 32'h00004000, 32'h0, 0);
    queue_vertex(32'h00008000, 32'h00004000, 32'hffff0000, 0);
    queue_vertex(32'h7fffffff, 32'h80000000, 32'h00000001, 0);
    queue_vertex(32'h00010000, 32'hffff0000, 32'h00020000, 1);
    drain();
    for (int phase = 0; phase < 12; phase++) begin
      int emode;
      emode = (phase == 0) ? 0 : $urandom_range(0, 3);
      for (int r = 0; r < NumRegs; r++) begin
        if (phase == 1) write_matrix(r, 64'hffff_ffff_ffff_ffff);
        else if (phase == 2) write_matrix(r, 64'h8000_0000_7fff_ffff);
        else write_matrix(r, {rand_entry(emode), rand_entry(emode)});
      end
      if (phase % 3 == 0) write_matrix(REG_R3C23, {32'h00010000, rand_entry(emode)});
      random_phase(150, $urandom_range(0, 3));
      drain();
    end
    $display("checked %0d vertices over 14 matrix settings incl. zero and saturating w",
             received);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
